// ----- rtl/mhma_pkg.sv -----
// Shared types and constants for the multichannel hysteresis moving average.
// No dependencies.
package mhma_pkg;

  localparam int VAL_W  = 13;
  localparam int SMP_W  = 12;
  localparam int CHAN_W = 3;
  localparam int OP_W   = 2;
  localparam int HW_W   = 10;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [HW_W-1:0]  hw_t;

  localparam val_t FULL_SCALE  = 13'd4096;
  localparam hw_t  WIDTH_LIMIT = 10'd1000;
  localparam hw_t  RESET_WIDTH = 10'd50;
  localparam val_t RESET_FLOOR = 13'd0;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE   = 2'd0,
    OP_SET_CAL  = 2'd1,
    OP_SET_HYST = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic {
    ST_OK     = 1'b0,
    ST_REJECT = 1'b1
  } status_t;

  typedef struct packed {
    val_t cal_floor;
    val_t cal_ceiling;
    hw_t  band_width;
    val_t band_low;
    val_t band_high;
  } chan_state_t;

  localparam chan_state_t STATE_RESET = '{
    cal_floor:   RESET_FLOOR,
    cal_ceiling: FULL_SCALE,
    band_width:  RESET_WIDTH,
    band_low:    RESET_FLOOR,
    band_high:   RESET_FLOOR + val_t'(RESET_WIDTH)
  };

endpackage

// ----- rtl/mhma_in_if.sv -----
// Input word channel: valid/ready handshake with op, channel and arguments.
// Depends on mhma_pkg.
interface mhma_in_if import mhma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [CHAN_W-1:0]   chan;
  logic [SMP_W-1:0]    sample;
  logic [VAL_W-1:0]    cal_low;
  logic [VAL_W-1:0]    cal_high;
  logic [HW_W-1:0]     hyst_width;

  modport source (output valid, op, chan, sample, cal_low, cal_high, hyst_width,
                  input ready);
  modport sink   (input valid, op, chan, sample, cal_low, cal_high, hyst_width,
                  output ready);
endinterface

// ----- rtl/mhma_out_if.sv -----
// Result word channel: valid/ready handshake with status and filter outputs.
// Depends on mhma_pkg.
interface mhma_out_if import mhma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                status;
  logic [CHAN_W-1:0]   chan_out;
  logic [VAL_W-1:0]    hyst_value;
  logic [VAL_W-1:0]    filtered;

  modport source (output valid, status, chan_out, hyst_value, filtered,
                  input ready);
  modport sink   (input valid, status, chan_out, hyst_value, filtered,
                  output ready);
endinterface

// ----- rtl/mhma_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module mhma_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mhma_update.sv -----
// Per-word state update: hysteresis band, calibration and width writes,
// running sum. Depends on mhma_pkg.
module mhma_update import mhma_pkg::*; #(
  parameter int SUM_W = 16
) (
  input  logic [OP_W-1:0]   op,
  input  logic              chan_ok,
  input  logic [SMP_W-1:0]  sample,
  input  val_t              cal_low,
  input  val_t              cal_high,
  input  hw_t               hyst_width,
  input  chan_state_t       cur,
  input  logic [SUM_W-1:0]  sum_cur,
  input  val_t              ring_old,
  output chan_state_t       nxt,
  output logic [SUM_W-1:0]  sum_nxt,
  output logic              status,
  output val_t              hyst_value,
  output logic              ring_we
);

  val_t             x;
  val_t             half;
  val_t             w;
  logic             in_band;
  val_t             mid;
  logic [VAL_W:0]   up_sum;
  val_t             up_high;
  val_t             up_low;
  val_t             dn_base;
  val_t             dn_low;
  logic [VAL_W:0]   dn_sum;
  val_t             dn_high;
  logic [VAL_W:0]   cal_sum;
  val_t             cal_band_high;

  assign x       = val_t'(sample);
  assign w       = val_t'(cur.band_width);
  assign half    = val_t'(cur.band_width[HW_W-1:1]);
  assign in_band = (x >= cur.band_low) && (x <= cur.band_high);
  assign mid     = cur.band_low + ((cur.band_high - cur.band_low) >> 1);

  assign up_sum  = {1'b0, x} + {1'b0, half};
  assign up_high = (up_sum > {1'b0, cur.cal_ceiling}) ? cur.cal_ceiling : up_sum[VAL_W-1:0];
  assign up_low  = (up_high > w) ? up_high - w : '0;

  assign dn_base = (x > half) ? x - half : '0;
  assign dn_low  = (dn_base > cur.cal_floor) ? dn_base : cur.cal_floor;
  assign dn_sum  = {1'b0, dn_low} + {1'b0, w};
  assign dn_high = (dn_sum > {1'b0, cur.cal_ceiling}) ? cur.cal_ceiling : dn_sum[VAL_W-1:0];

  assign cal_sum       = {1'b0, cal_low} + {1'b0, w};
  assign cal_band_high = (cal_sum > {1'b0, cal_high}) ? cal_high : cal_sum[VAL_W-1:0];

  always_comb begin
    nxt        = cur;
    sum_nxt    = sum_cur;
    status     = ST_REJECT;
    hyst_value = '0;
    ring_we    = 1'b0;
    if (chan_ok) begin
      unique case (op_t'(op))
        OP_SAMPLE: begin
          status  = ST_OK;
          ring_we = 1'b1;
          if (in_band) begin
            hyst_value = mid;
          end else if (x > cur.band_high) begin
            hyst_value    = x;
            nxt.band_high = up_high;
            nxt.band_low  = up_low;
          end else begin
            hyst_value    = x;
            nxt.band_low  = dn_low;
            nxt.band_high = dn_high;
          end
          sum_nxt = sum_cur - SUM_W'(ring_old) + SUM_W'(hyst_value);
        end
        OP_SET_CAL: begin
          if ((cal_low < cal_high) && (cal_high <= FULL_SCALE)) begin
            status          = ST_OK;
            nxt.cal_floor   = cal_low;
            nxt.cal_ceiling = cal_high;
            nxt.band_low    = cal_low;
            nxt.band_high   = cal_band_high;
          end
        end
        OP_SET_HYST: begin
          if ((hyst_width != '0) && (hyst_width <= WIDTH_LIMIT)) begin
            status         = ST_OK;
            nxt.band_width = hyst_width;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/mhma_avg_div.sv -----
// Running sum divided by the averaging depth via reciprocal multiply.
// Depends on mhma_pkg.
module mhma_avg_div import mhma_pkg::*; #(
  parameter int AVG_DEPTH = 10,
  parameter int SUM_W     = 16
) (
  input  logic [SUM_W-1:0] sum,
  output val_t             avg
);

  localparam int SH = SUM_W + $clog2(AVG_DEPTH);
  localparam int MW = SH + 1;
  localparam longint unsigned RECIP = ((64'd1 << SH) + AVG_DEPTH - 1) / AVG_DEPTH;

  logic [SUM_W+MW-1:0] prod;

  assign prod = (SUM_W+MW)'(sum) * (SUM_W+MW)'(MW'(RECIP));
  assign avg  = prod[SH +: VAL_W];

endmodule

// ----- rtl/multichannel_hysteresis_moving_average.sv -----
// Multichannel hysteresis band with moving average, top level.
// Depends on mhma_pkg, mhma_in_if, mhma_out_if, mhma_ram, mhma_update, mhma_avg_div.
//
// Usage: words enter on the samples channel (op, chan and arguments) and
// exactly one result word per input leaves on the results channel, in order.
// One word per cycle is sustained for any channel mix while results.ready is
// high, as the read-modify-write of the per-channel state RAM and of the
// averaging ring RAM uses write-to-read forwarding.
// Per-channel state and the running sum sit in a CHANNELS-deep RAM; the
// averaging ring sits in a CHANNELS*AVG_DEPTH RAM. Reset clears per-channel
// seeded and wrap flags, so state reads as its default and ring slots read
// as zero until first written; no clearing pass is needed.
// When results.ready is low the pipeline keeps filling until its three
// stages hold words, then samples.ready drops; nothing is lost or repeated.
module multichannel_hysteresis_moving_average import mhma_pkg::*; #(
  parameter int CHANNELS  = 4,
  parameter int AVG_DEPTH = 10
) (
  input  logic      clk,
  input  logic      rst,
  mhma_in_if.sink   samples,
  mhma_out_if.source results
);

  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW         = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int RING_DEPTH = CHANNELS * AVG_DEPTH;
  localparam int RA_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W      = $clog2(AVG_DEPTH * 4096 + 1);
  localparam int ST_W       = $bits(chan_state_t) + SUM_W;

  // stage 0
  logic              acc;
  logic              chan_ok0;
  logic [CH_AW-1:0]  cidx0;
  logic [PW-1:0]     posr0;
  logic              wrap0;
  logic [RA_W-1:0]   raddr0;

  logic [PW-1:0]     pos [CHANNELS];
  logic              wrapped [CHANNELS];
  logic              seeded [CHANNELS];

  // stage 1
  logic              v1;
  logic [OP_W-1:0]   op1;
  logic [CHAN_W-1:0] chan1;
  logic [SMP_W-1:0]  sample1;
  val_t              cal_low1;
  val_t              cal_high1;
  hw_t               hw1;
  logic              ok1;
  logic [CH_AW-1:0]  cidx1;
  logic [RA_W-1:0]   raddr1;
  logic              seeded1;
  logic              oldv1;
  logic              fwd_st1;
  logic [ST_W-1:0]   fwd_st_data;
  logic              fwd_r1;
  val_t              fwd_r_data;

  logic [ST_W-1:0]   st_q;
  val_t              ring_q;
  logic [ST_W-1:0]   st_word;
  chan_state_t       cur;
  logic [SUM_W-1:0]  sum_cur;
  val_t              ring_old;
  chan_state_t       nxt;
  logic [SUM_W-1:0]  sum_nxt;
  logic              status_u;
  val_t              hv_u;
  logic              ring_we_u;
  logic              adv1;
  logic              st_we;
  logic              ring_we;

  // stage 2
  logic              v2;
  logic              status2;
  logic [CHAN_W-1:0] chan2;
  val_t              hv2;
  logic [SUM_W-1:0]  sum2;
  val_t              avg2;
  logic              r2;

  // stage 3
  logic              v3;
  logic              status3;
  logic [CHAN_W-1:0] chan3;
  val_t              hv3;
  val_t              filt3;
  logic              r3;

  assign r3 = !v3 || results.ready;
  assign r2 = !v2 || r3;
  assign adv1 = v1 && r2;
  assign samples.ready = !v1 || r2;
  assign acc = samples.valid && samples.ready;

  assign chan_ok0 = {1'b0, samples.chan} < (CHAN_W+1)'(CHANNELS);
  assign cidx0    = chan_ok0 ? CH_AW'(samples.chan) : '0;
  assign posr0    = pos[cidx0];
  assign wrap0    = (posr0 == PW'(AVG_DEPTH - 1));
  assign raddr0   = RA_W'(cidx0) * RA_W'(AVG_DEPTH) + RA_W'(posr0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos[i]     <= '0;
        wrapped[i] <= 1'b0;
        seeded[i]  <= 1'b0;
      end
    end else begin
      if (acc && chan_ok0 && (samples.op == OP_SAMPLE)) begin
        pos[cidx0] <= wrap0 ? '0 : posr0 + 1'b1;
        if (wrap0) begin
          wrapped[cidx0] <= 1'b1;
        end
      end
      if (st_we) begin
        seeded[cidx1] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (samples.ready) begin
      v1 <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op1         <= samples.op;
      chan1       <= samples.chan;
      sample1     <= samples.sample;
      cal_low1    <= samples.cal_low;
      cal_high1   <= samples.cal_high;
      hw1         <= samples.hyst_width;
      ok1         <= chan_ok0;
      cidx1       <= cidx0;
      raddr1      <= raddr0;
      seeded1     <= seeded[cidx0];
      oldv1       <= wrapped[cidx0];
      fwd_st1     <= st_we && (cidx1 == cidx0);
      fwd_st_data <= {nxt, sum_nxt};
      fwd_r1      <= ring_we && (raddr1 == raddr0);
      fwd_r_data  <= hv_u;
    end
  end

  mhma_ram #(.DEPTH(CHANNELS), .WIDTH(ST_W)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (cidx1),
    .wdata ({nxt, sum_nxt}),
    .re    (acc),
    .raddr (cidx0),
    .rdata (st_q)
  );

  mhma_ram #(.DEPTH(RING_DEPTH), .WIDTH(VAL_W)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (raddr1),
    .wdata (hv_u),
    .re    (acc),
    .raddr (raddr0),
    .rdata (ring_q)
  );

  assign st_word  = fwd_st1 ? fwd_st_data
                  : (seeded1 ? st_q : {STATE_RESET, SUM_W'(0)});
  assign cur      = chan_state_t'(st_word[ST_W-1:SUM_W]);
  assign sum_cur  = st_word[SUM_W-1:0];
  assign ring_old = fwd_r1 ? fwd_r_data : (oldv1 ? ring_q : '0);

  mhma_update #(.SUM_W(SUM_W)) u_update (
    .op         (op1),
    .chan_ok    (ok1),
    .sample     (sample1),
    .cal_low    (cal_low1),
    .cal_high   (cal_high1),
    .hyst_width (hw1),
    .cur        (cur),
    .sum_cur    (sum_cur),
    .ring_old   (ring_old),
    .nxt        (nxt),
    .sum_nxt    (sum_nxt),
    .status     (status_u),
    .hyst_value (hv_u),
    .ring_we    (ring_we_u)
  );

  assign st_we   = adv1 && ok1;
  assign ring_we = adv1 && ring_we_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      status2 <= status_u;
      chan2   <= chan1;
      hv2     <= hv_u;
      sum2    <= ring_we_u ? sum_nxt : '0;
    end
  end

  mhma_avg_div #(.AVG_DEPTH(AVG_DEPTH), .SUM_W(SUM_W)) u_avg_div (
    .sum (sum2),
    .avg (avg2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && r3) begin
      status3 <= status2;
      chan3   <= chan2;
      hv3     <= hv2;
      filt3   <= avg2;
    end
  end

  assign results.valid      = v3;
  assign results.status     = status3;
  assign results.chan_out   = chan3;
  assign results.hyst_value = hv3;
  assign results.filtered   = filt3;

endmodule
